// ===== hdl/led_pixel_gamma_ws2812_encoder_top_macros.svh =====
// Assertion macros shared by the checker of the WS2812 encoder.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LED_PIXEL_GAMMA_WS2812_ENCODER_TOP_MACROS_SVH
`define LED_PIXEL_GAMMA_WS2812_ENCODER_TOP_MACROS_SVH

// Checked on every rising edge outside reset.
`define LPGWS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LPGWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lpgws_pkg.sv =====
// Shared types, codes and helpers of the WS2812 encoder with gamma table.
// No dependencies; imported by every module of the block except lpgws_ram.
package lpgws_pkg;

  localparam int TickW             = 15;  // tick fields on the ports
  localparam int TickBitsDefault   = 15;
  localparam int QueueDepthDefault = 2;
  localparam int FmtW              = 3;
  localparam int CfgIdxW           = 3;
  localparam int GammaDepth        = 256;
  localparam int GammaAw           = 8;
  localparam int SymbolsPerPixel   = 24;

  localparam int FormatRst    = 0;
  localparam int BppRst       = 3;
  localparam int BppFour      = 4;
  localparam int ShortRst     = 3;
  localparam int LongRst      = 9;
  localparam int ResetHalfRst = 250;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_PIXEL  = 2'd1,
    MODE_EOF    = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    FMT_RGB  = 3'd0,
    FMT_RGBW = 3'd1,
    FMT_GRB  = 3'd2,
    FMT_GRBW = 3'd3,
    FMT_BGR  = 3'd4
  } fmt_e;

  typedef enum logic [2:0] {
    CFG_PIXEL_FORMAT = 3'd0,
    CFG_BYTES_PER_PX = 3'd1,
    CFG_SHORT_TICKS  = 3'd2,
    CFG_LONG_TICKS   = 3'd3,
    CFG_RESET_HALF   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_EOF   = 2'd2
  } kind_e;

  // Queue word. Table load: val0 index, val1 value. Pixel: val0 G, val1 R, val2 B.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] val0;
    logic [7:0] val1;
    logic [7:0] val2;
  } entry_t;

  typedef enum logic [1:0] {
    FETCH_IDLE = 2'd0,
    FETCH_R    = 2'd1,
    FETCH_B    = 2'd2,
    FETCH_LAST = 2'd3
  } fetch_e;

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

// ===== hdl/lpgws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the gamma table.
module lpgws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/lpgws_front.sv =====
// Front end: takes input words, unpacks pixels by format, folds white.
// Depends on lpgws_pkg; feeds lpgws_fifo.
module lpgws_front import lpgws_pkg::*; (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      mode_i,
  input  logic [7:0]      table_index_i,
  input  logic [7:0]      table_value_i,
  input  logic [7:0]      first_byte_i,
  input  logic [7:0]      second_byte_i,
  input  logic [7:0]      third_byte_i,
  input  logic [7:0]      fourth_byte_i,
  input  logic [FmtW-1:0] pixel_format_i,
  input  logic            four_bytes_i,
  input  logic            q_full_i,
  output logic            push_o,
  output entry_t          push_data_o
);

  logic       accept;
  logic [7:0] r, g, b, w;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    r = first_byte_i;
    g = second_byte_i;
    b = third_byte_i;
    w = 8'd0;
    case (pixel_format_i)
      FMT_RGBW: begin
        w = fourth_byte_i;
      end
      FMT_GRB: begin
        g = first_byte_i;
        r = second_byte_i;
      end
      FMT_GRBW: begin
        g = first_byte_i;
        r = second_byte_i;
        w = fourth_byte_i;
      end
      FMT_BGR: begin
        b = first_byte_i;
        r = third_byte_i;
      end
      default: begin
      end
    endcase
    if (four_bytes_i) begin
      r = sat_add8(r, w);
      g = sat_add8(g, w);
      b = sat_add8(b, w);
    end
  end

  always_comb begin
    push_o      = 1'b0;
    push_data_o = '{kind: KIND_LOAD, val0: table_index_i, val1: table_value_i, val2: 8'd0};
    case (mode_i)
      MODE_LOAD: begin
        push_o = accept;
      end
      MODE_PIXEL: begin
        push_o      = accept;
        push_data_o = '{kind: KIND_PIXEL, val0: g, val1: r, val2: b};
      end
      MODE_EOF: begin
        push_o           = accept;
        push_data_o.kind = KIND_EOF;
      end
      default: begin
        push_o = 1'b0;  // unused mode is dropped
      end
    endcase
  end

endmodule

// ===== hdl/lpgws_fifo.sv =====
// Short queue between front end and back end.
// Depends on lpgws_pkg for the queue word type.
module lpgws_fifo import lpgws_pkg::*; #(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t head_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t            mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/lpgws_back.sv =====
// Back end: gamma table updates and lookups, then serial symbol output.
// Depends on lpgws_pkg and lpgws_ram; fed by lpgws_fifo.
module lpgws_back import lpgws_pkg::*; #(
  parameter int TICK_W = TickBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  entry_t            head_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic [TICK_W-1:0] short_ticks_i,
  input  logic [TICK_W-1:0] long_ticks_i,
  input  logic [TICK_W-1:0] reset_half_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              first_level_o,
  output logic [TickW-1:0]  first_ticks_o,
  output logic              second_level_o,
  output logic [TickW-1:0]  second_ticks_o,
  output logic              last_o
);

  localparam int RemW = $clog2(SymbolsPerPixel);
  localparam int SymW = SymbolsPerPixel;

  // ---- fetch stage ----
  fetch_e            state_q, state_d;
  logic [7:0]        pend_r_q, pend_b_q;
  logic              pend_ld;
  logic              ram_we, ram_re;
  logic [GammaAw-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              cap_g, cap_r, cap_b, set_eof, set_pix;

  logic              stg_valid_q, stg_valid_d;
  logic              stg_eof_q;
  logic [SymW-1:0]   stg_bits_q;
  logic              stg_take;

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_i.val0;
    pend_ld   = 1'b0;
    cap_g     = 1'b0;
    cap_r     = 1'b0;
    cap_b     = 1'b0;
    set_eof   = 1'b0;
    set_pix   = 1'b0;
    case (state_q)
      FETCH_IDLE: begin
        if (!empty_i) begin
          case (head_i.kind)
            KIND_LOAD: begin
              pop_o  = 1'b1;
              ram_we = 1'b1;
            end
            KIND_PIXEL: begin
              if (!stg_valid_q) begin
                pop_o   = 1'b1;
                ram_re  = 1'b1;  // G lookup
                pend_ld = 1'b1;
                state_d = FETCH_R;
              end
            end
            KIND_EOF: begin
              if (!stg_valid_q) begin
                pop_o   = 1'b1;
                set_eof = 1'b1;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      FETCH_R: begin
        ram_re    = 1'b1;
        ram_raddr = pend_r_q;
        cap_g     = 1'b1;
        state_d   = FETCH_B;
      end
      FETCH_B: begin
        ram_re    = 1'b1;
        ram_raddr = pend_b_q;
        cap_r     = 1'b1;
        state_d   = FETCH_LAST;
      end
      FETCH_LAST: begin
        cap_b   = 1'b1;
        set_pix = 1'b1;
        state_d = FETCH_IDLE;
      end
      default: begin
        state_d = FETCH_IDLE;
      end
    endcase
  end

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (set_eof || set_pix) begin
      stg_valid_d = 1'b1;
    end else if (stg_take) begin
      stg_valid_d = 1'b0;
    end
  end

  lpgws_ram #(
    .WIDTH(8),
    .DEPTH(GammaDepth)
  ) u_gamma (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(head_i.val0),
    .wdata_i(head_i.val1),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // ---- send stage ----
  logic              ld;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [SymW-1:0]   sh_q, sh_d;
  logic              out_valid_q, out_valid_d;
  logic              out_level_d, out_last_d;
  logic [TickW-1:0]  out_t0_d, out_t1_d;
  logic              sym_bit;

  assign ld = !out_valid_q || !out_stall_i;

  always_comb begin
    rem_d       = rem_q;
    sh_d        = sh_q;
    out_valid_d = out_valid_q;
    out_level_d = 1'b1;
    out_last_d  = 1'b0;
    stg_take    = 1'b0;
    sym_bit     = sh_q[SymW-1];
    if (ld) begin
      out_valid_d = 1'b0;
      if (rem_q != '0) begin
        out_valid_d = 1'b1;
        sh_d        = {sh_q[SymW-2:0], 1'b0};
        rem_d       = rem_q - 1'b1;
        out_last_d  = (rem_q == RemW'(1));
      end else if (stg_valid_q) begin
        out_valid_d = 1'b1;
        stg_take    = 1'b1;
        if (stg_eof_q) begin
          out_level_d = 1'b0;
          out_last_d  = 1'b1;
        end else begin
          sym_bit = stg_bits_q[SymW-1];
          sh_d    = {stg_bits_q[SymW-2:0], 1'b0};
          rem_d   = RemW'(SymbolsPerPixel - 1);
        end
      end
    end
    if (!out_level_d) begin
      out_t0_d = TickW'(reset_half_i);
      out_t1_d = TickW'(reset_half_i);
    end else if (sym_bit) begin
      out_t0_d = TickW'(long_ticks_i);
      out_t1_d = TickW'(short_ticks_i);
    end else begin
      out_t0_d = TickW'(short_ticks_i);
      out_t1_d = TickW'(long_ticks_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FETCH_IDLE;
      stg_valid_q <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stg_valid_q <= stg_valid_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_ld) begin
      pend_r_q <= head_i.val1;
      pend_b_q <= head_i.val2;
    end
    if (cap_g) begin
      stg_bits_q[23:16] <= ram_rdata;
    end
    if (cap_r) begin
      stg_bits_q[15:8] <= ram_rdata;
    end
    if (cap_b) begin
      stg_bits_q[7:0] <= ram_rdata;
    end
    if (set_eof || set_pix) begin
      stg_eof_q <= set_eof;
    end
    sh_q <= sh_d;
    if (ld) begin
      first_level_o  <= out_level_d;
      first_ticks_o  <= out_t0_d;
      second_ticks_o <= out_t1_d;
      last_o         <= out_last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign second_level_o = 1'b0;

endmodule

// ===== hdl/led_pixel_gamma_ws2812_encoder_top.sv =====
// WS2812 encoder with gamma table: words in, one bit symbol out per cycle
// unless the output stalls. A pixel's word passes the queue, the G, R and B
// gamma lookups and a staging register, so the next pixel is fetched while
// the previous one shifts out. Table loads retire one per cycle while fetch is idle.
// Reset (async, active low) empties queue and pipeline and restores config;
// the gamma RAM is not cleared and holds garbage until loaded.
module led_pixel_gamma_ws2812_encoder_top import lpgws_pkg::*; #(
  parameter int TICK_BITS   = TickBitsDefault,  // 8..16, tick register width, capped at TickW
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [TickW-1:0]   cfg_wdata_i,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         table_value_i,
  input  logic [7:0]         first_byte_i,
  input  logic [7:0]         second_byte_i,
  input  logic [7:0]         third_byte_i,
  input  logic [7:0]         fourth_byte_i,
  // symbol words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               first_level_o,
  output logic [TickW-1:0]   first_ticks_o,
  output logic               second_level_o,
  output logic [TickW-1:0]   second_ticks_o,
  output logic               last_o
);

  // Ticks are held at TICK_BITS bits, but no wider than the TickW the ports carry.
  localparam int KeepW = (TICK_BITS < TickW) ? TICK_BITS : TickW;

  // Config registers. The user must write them only while the block is idle; the block does not enforce it.
  logic [FmtW-1:0]  pixel_format_q;
  logic [FmtW-1:0]  bpp_q;
  logic [KeepW-1:0] short_q, long_q, reset_half_q;
  logic             cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= FmtW'(FormatRst);
      bpp_q          <= FmtW'(BppRst);
      short_q        <= KeepW'(ShortRst);
      long_q         <= KeepW'(LongRst);
      reset_half_q   <= KeepW'(ResetHalfRst);
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_PIXEL_FORMAT: pixel_format_q <= cfg_wdata_i[FmtW-1:0];
        CFG_BYTES_PER_PX: bpp_q          <= cfg_wdata_i[FmtW-1:0];
        CFG_SHORT_TICKS:  short_q        <= cfg_wdata_i[KeepW-1:0];
        CFG_LONG_TICKS:   long_q         <= cfg_wdata_i[KeepW-1:0];
        CFG_RESET_HALF:   reset_half_q   <= cfg_wdata_i[KeepW-1:0];
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  // Front end -> queue -> back end. The queue lets the front keep taking
  // words (table loads, next pixel) while the back end is busy shifting.
  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_head;

  lpgws_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .first_byte_i  (first_byte_i),
    .second_byte_i (second_byte_i),
    .third_byte_i  (third_byte_i),
    .fourth_byte_i (fourth_byte_i),
    .pixel_format_i(pixel_format_q),
    .four_bytes_i  (bpp_q == FmtW'(BppFour)),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .push_data_o   (q_wdata)
  );

  lpgws_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  // Table loads go through the queue too, so a load never overtakes a
  // pixel that was taken before it.
  lpgws_back #(
    .TICK_W(KeepW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .short_ticks_i (short_q),
    .long_ticks_i  (long_q),
    .reset_half_i  (reset_half_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .first_level_o (first_level_o),
    .first_ticks_o (first_ticks_o),
    .second_level_o(second_level_o),
    .second_ticks_o(second_ticks_o),
    .last_o        (last_o)
  );

endmodule

// ===== hdl/lpgws_checker.sv =====
// Port-level checks of the WS2812 encoder, bound to the top level.
// Depends on lpgws_pkg and the assertion macro header.
`include "led_pixel_gamma_ws2812_encoder_top_macros.svh"

module lpgws_checker import lpgws_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               first_level_o,
  input logic [TickW-1:0]   first_ticks_o,
  input logic               second_level_o,
  input logic [TickW-1:0]   second_ticks_o,
  input logic               last_o
);

  // no symbol while in reset
  `LPGWS_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, (!rst_ni |-> !out_valid_o), "symbol valid during reset")

  // stalled symbol holds
  `LPGWS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i |=> out_valid_o && $stable(first_level_o) && $stable(first_ticks_o) && $stable(second_ticks_o) && $stable(last_o)), "stalled symbol changed")

  // reset symbol: low, symmetric halves, ends its word
  `LPGWS_ASSERT(a_eof_shape, clk_i, rst_ni, (out_valid_o && !first_level_o |-> last_o && !second_level_o && (first_ticks_o == second_ticks_o)), "bad reset symbol")

  // data symbols of one pixel go out back to back
  `LPGWS_ASSERT(a_pixel_burst, clk_i, rst_ni, (out_valid_o && !out_stall_i && first_level_o && !last_o |=> out_valid_o && first_level_o), "gap inside pixel")

endmodule

bind led_pixel_gamma_ws2812_encoder_top lpgws_checker u_lpgws_checker (.*);

// ===== tb/sv/tb_led_pixel_gamma_ws2812_encoder_top.sv =====
// Self-checking testbench for led_pixel_gamma_ws2812_encoder_top.
// Needs lpgws_pkg and the encoder RTL; a clocked driver and monitor carry the words.
module tb_led_pixel_gamma_ws2812_encoder_top;
  import lpgws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit  = 20000;  // cycles with work pending but no handshake
  localparam int DrainCycles = 24;     // queue and pipeline, with margin
  localparam int PhaseWords  = 19;     // random words per config phase

  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;  // no register behind it
  localparam logic [FmtW-1:0]    FmtUnknown   = 3'd6;  // decodes as RGB

  // One input word, all fields present whatever the mode.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] tbl_idx;
    logic [7:0] tbl_val;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } led_word_t;

  // One bit symbol as it leaves the encoder.
  typedef struct packed {
    logic             first_level;
    logic [TickW-1:0] first_ticks;
    logic             second_level;
    logic [TickW-1:0] second_ticks;
    logic             last;
  } symbol_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [TickW-1:0]   data;
  } reg_write_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  // Everything the bench drives starts at a known value.
  logic               cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [TickW-1:0]   cfg_wdata  = '0;
  logic               in_valid   = 1'b0;
  logic [1:0]         in_mode    = '0;
  logic [7:0]         in_tbl_idx = '0;
  logic [7:0]         in_tbl_val = '0;
  logic [7:0]         in_b0      = '0;
  logic [7:0]         in_b1      = '0;
  logic [7:0]         in_b2      = '0;
  logic [7:0]         in_b3      = '0;
  logic               out_stall  = 1'b0;

  logic               cfg_ready_o;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               first_level_o;
  logic [TickW-1:0]   first_ticks_o;
  logic               second_level_o;
  logic [TickW-1:0]   second_ticks_o;
  logic               last_o;

  // Shadow of the config registers and the gamma RAM, kept by the predictor.
  logic [FmtW-1:0]  fmt_sh   = FmtW'(FormatRst);
  logic [2:0]       bpp_sh   = 3'(BppRst);
  logic [TickW-1:0] short_sh = TickW'(ShortRst);
  logic [TickW-1:0] long_sh  = TickW'(LongRst);
  logic [TickW-1:0] rhalf_sh = TickW'(ResetHalfRst);
  logic [7:0]       gamma_sh [GammaDepth];

  led_word_t word_backlog [$];  // words waiting for the driver
  symbol_t   symbol_due [$];    // symbols predicted, not yet seen
  led_word_t on_wire;           // word currently presented on the input port

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fault_count   = 0;
  int quiet_cycles  = 0;

  led_pixel_gamma_ws2812_encoder_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .mode_i         (in_mode),
    .table_index_i  (in_tbl_idx),
    .table_value_i  (in_tbl_val),
    .first_byte_i   (in_b0),
    .second_byte_i  (in_b1),
    .third_byte_i   (in_b2),
    .fourth_byte_i  (in_b3),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .first_level_o  (first_level_o),
    .first_ticks_o  (first_ticks_o),
    .second_level_o (second_level_o),
    .second_ticks_o (second_ticks_o),
    .last_o         (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: saturating add used by white folding.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] brighten(input logic [7:0] c, input logic [7:0] w);
    logic [8:0] sum;
    sum = {1'b0, c} + {1'b0, w};
    return (sum > 9'd255) ? 8'd255 : sum[7:0];
  endfunction

  // Works out what one accepted word does: a gamma write, one reset symbol,
  // 24 data symbols (G, R, B, MSB first) or nothing at all.
  function void encode_word(input led_word_t w);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  wh;
    logic [23:0] grb;
    symbol_t     s;
    r  = w.b0;
    g  = w.b1;
    b  = w.b2;
    wh = 8'd0;
    case (w.mode)
      MODE_LOAD: gamma_sh[w.tbl_idx] = w.tbl_val;
      MODE_EOF: begin
        s.first_level  = 1'b0;
        s.first_ticks  = rhalf_sh;
        s.second_level = 1'b0;
        s.second_ticks = rhalf_sh;
        s.last         = 1'b1;
        symbol_due.push_back(s);
      end
      MODE_PIXEL: begin
        // formats 5..7 fall through to plain RGB
        case (fmt_sh)
          FMT_RGBW: wh = w.b3;
          FMT_GRB: begin
            g = w.b0;
            r = w.b1;
          end
          FMT_GRBW: begin
            g  = w.b0;
            r  = w.b1;
            wh = w.b3;
          end
          FMT_BGR: begin
            b = w.b0;
            r = w.b2;
          end
          default: ;
        endcase
        // white only folds in for four-byte pixels of a W format
        if (bpp_sh == BppFour && wh != 8'd0) begin
          r = brighten(r, wh);
          g = brighten(g, wh);
          b = brighten(b, wh);
        end
        grb = {gamma_sh[g], gamma_sh[r], gamma_sh[b]};
        for (int k = 23; k >= 0; k--) begin
          s.first_level  = 1'b1;
          s.first_ticks  = grb[k] ? long_sh : short_sh;
          s.second_level = 1'b0;
          s.second_ticks = grb[k] ? short_sh : long_sh;
          s.last         = (k == 0);
          symbol_due.push_back(s);
        end
      end
      default: ;  // unused mode, dropped by the block
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders. Fields that the mode does not use stay random.
  // ---------------------------------------------------------------------------
  function automatic led_word_t noise_word();
    led_word_t w;
    w.mode    = 2'($urandom_range(3));
    w.tbl_idx = 8'($urandom_range(255));
    w.tbl_val = 8'($urandom_range(255));
    w.b0      = 8'($urandom_range(255));
    w.b1      = 8'($urandom_range(255));
    w.b2      = 8'($urandom_range(255));
    w.b3      = 8'($urandom_range(255));
    return w;
  endfunction

  function automatic led_word_t load_word(input logic [7:0] idx, input logic [7:0] val);
    led_word_t w;
    w         = noise_word();
    w.mode    = MODE_LOAD;
    w.tbl_idx = idx;
    w.tbl_val = val;
    return w;
  endfunction

  function automatic led_word_t pixel_word(input logic [7:0] p0, input logic [7:0] p1,
                                           input logic [7:0] p2, input logic [7:0] p3);
    led_word_t w;
    w      = noise_word();
    w.mode = MODE_PIXEL;
    w.b0   = p0;
    w.b1   = p1;
    w.b2   = p2;
    w.b3   = p3;
    return w;
  endfunction

  function automatic led_word_t eof_word();
    led_word_t w;
    w      = noise_word();
    w.mode = MODE_EOF;
    return w;
  endfunction

  function automatic led_word_t ignored_word();
    led_word_t w;
    w      = noise_word();
    w.mode = MODE_IGNORE;
    return w;
  endfunction

  // Bytes come from the loaded grid (multiples of 16 and 0xFF); saturating
  // sums stay on it. Extremes lean in so saturation and all-0/all-1 show up.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return {4'($urandom_range(15)), 4'h0};
    endcase
  endfunction

  function automatic logic [TickW-1:0] pick_ticks();
    case ($urandom_range(3))
      0:       return TickW'(1);
      1:       return 15'h7FFF;
      default: return TickW'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic reg_write_t cfg_word(input logic [CfgIdxW-1:0] idx,
                                          input logic [TickW-1:0] data);
    reg_write_t wr;
    wr.idx  = idx;
    wr.data = data;
    return wr;
  endfunction

  // ---------------------------------------------------------------------------
  // Config writes, only while the encoder is idle. Valid stays up across the
  // burst so it never sees two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic program_regs(input logic [FmtW-1:0] fmt, input logic [2:0] bpp,
                              input logic [TickW-1:0] sht, input logic [TickW-1:0] lng,
                              input logic [TickW-1:0] rhalf, input bit poke_unused);
    reg_write_t burst [$];
    if (poke_unused)
      burst.push_back(cfg_word(CfgIdxUnused, TickW'($urandom_range(32767))));
    burst.push_back(cfg_word(CFG_PIXEL_FORMAT, TickW'(fmt)));
    burst.push_back(cfg_word(CFG_BYTES_PER_PX, TickW'(bpp)));
    burst.push_back(cfg_word(CFG_SHORT_TICKS, sht));
    burst.push_back(cfg_word(CFG_LONG_TICKS, lng));
    burst.push_back(cfg_word(CFG_RESET_HALF, rhalf));
    foreach (burst[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= burst[k].idx;
      cfg_wdata <= burst[k].data;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (burst[k].idx)
        CFG_PIXEL_FORMAT: fmt_sh   = burst[k].data[FmtW-1:0];
        CFG_BYTES_PER_PX: bpp_sh   = burst[k].data[2:0];
        CFG_SHORT_TICKS:  short_sh = burst[k].data;
        CFG_LONG_TICKS:   long_sh  = burst[k].data;
        CFG_RESET_HALF:   rhalf_sh = burst[k].data;
        default: ;  // unknown index, register file untouched
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Waits until every word went in and every symbol came out, then gives
  // trailing table loads time to retire. Checked at the falling edge, once
  // the driver and monitor have settled for the cycle.
  task automatic settle();
    while (word_backlog.size() != 0 || in_valid || symbol_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: presents the next word unless stalled or idling on purpose.
  // The word goes to the predictor at the edge it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o)
        encode_word(on_wire);
      if (!in_valid || !in_stall_o) begin
        if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_wire = word_backlog.pop_front();
          in_valid   <= 1'b1;
          in_mode    <= on_wire.mode;
          in_tbl_idx <= on_wire.tbl_idx;
          in_tbl_val <= on_wire.tbl_val;
          in_b0      <= on_wire.b0;
          in_b1      <= on_wire.b1;
          in_b2      <= on_wire.b2;
          in_b3      <= on_wire.b3;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Symbol monitor: every taken symbol must match the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : symbol_mon
    symbol_t got;
    symbol_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        got = {first_level_o, first_ticks_o, second_level_o, second_ticks_o, last_o};
        if (symbol_due.size() == 0) begin
          $error("symbol with nothing predicted: %p", got);
          fault_count++;
        end else begin
          want = symbol_due.pop_front();
          if (got.first_level !== want.first_level) begin
            $error("first_level: expected %0d, actual %0d", want.first_level,
                   got.first_level);
            fault_count++;
          end
          if (got.first_ticks !== want.first_ticks) begin
            $error("first_ticks: expected %0d, actual %0d", want.first_ticks,
                   got.first_ticks);
            fault_count++;
          end
          if (got.second_level !== want.second_level) begin
            $error("second_level: expected %0d, actual %0d", want.second_level,
                   got.second_level);
            fault_count++;
          end
          if (got.second_ticks !== want.second_ticks) begin
            $error("second_ticks: expected %0d, actual %0d", want.second_ticks,
                   got.second_ticks);
            fault_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fault_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: only counts while work is outstanding and no channel moves.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni ||
        (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o) ||
        !(word_backlog.size() != 0 || in_valid || cfg_valid || symbol_due.size() != 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: gamma fill, directed phases, then random frames under random
  // configs. Idle mix: sender-light/receiver-heavy, swapped, then none.
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    int len;
    int n_words;

    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26;
    recv_idle_pct = 79;

    // Gamma RAM is garbage after reset: fill the grid of entries that pixels
    // use (multiples of 16 and 0xFF) before any pixel. Entry 0 and 255 pinned
    // so black/white pixels give all-0/all-1 symbols.
    for (int i = 0; i < 16; i++)
      word_backlog.push_back(load_word(8'(i * 16), (i == 0) ? 8'h00 :
                                                   8'($urandom_range(255))));
    word_backlog.push_back(load_word(8'hFF, 8'hFF));

    // Reset config: RGB, three bytes, 3/9/250 ticks.
    word_backlog.push_back(pixel_word(8'h00, 8'h00, 8'h00, 8'h00));
    word_backlog.push_back(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    word_backlog.push_back(pixel_word(8'h10, 8'h30, 8'h50, 8'hFF));  // no white in RGB
    word_backlog.push_back(eof_word());
    word_backlog.push_back(ignored_word());
    word_backlog.push_back(load_word(8'h50, 8'hA5));                 // overwrite, then use
    word_backlog.push_back(pixel_word(8'h50, 8'h50, 8'h50, 8'h00));
    settle();

    // RGBW with folding; tick extremes.
    program_regs(FMT_RGBW, 3'(BppFour), 15'd1, 15'h7FFF, 15'h7FFF, 1'b0);
    word_backlog.push_back(pixel_word(8'hF0, 8'h10, 8'h00, 8'h20));  // red saturates
    word_backlog.push_back(pixel_word(8'h30, 8'h60, 8'h90, 8'h00));  // zero white
    word_backlog.push_back(pixel_word(8'h01, 8'h80, 8'hFE, 8'hFF));  // all saturate
    word_backlog.push_back(eof_word());
    settle();

    // GRBW but three bytes: white ignored. Zero ticks and a stray register write.
    program_regs(FMT_GRBW, 3'(BppRst), 15'd0, 15'd0, 15'd0, 1'b1);
    word_backlog.push_back(pixel_word(8'h10, 8'hF0, 8'h30, 8'hFF));
    word_backlog.push_back(eof_word());
    settle();

    // GRB has no white even with four bytes.
    program_regs(FMT_GRB, 3'(BppFour), 15'h7FFF, 15'd1, 15'd1, 1'b0);
    word_backlog.push_back(pixel_word(8'hA0, 8'h50, 8'hC0, 8'h80));
    word_backlog.push_back(eof_word());
    settle();

    program_regs(FMT_BGR, 3'(BppFour), 15'h5555, 15'h2AAA, 15'h1234, 1'b0);
    word_backlog.push_back(pixel_word(8'h10, 8'h20, 8'h30, 8'hFF));
    word_backlog.push_back(eof_word());
    settle();

    // Undefined format code decodes as RGB.
    program_regs(FmtUnknown, 3'(BppFour), 15'd3, 15'd9, 15'd250, 1'b0);
    word_backlog.push_back(pixel_word(8'hC0, 8'h00, 8'h70, 8'hFF));
    word_backlog.push_back(eof_word());
    settle();

    // Random phases: mostly frames of pixels closed by end of frame, with
    // some table rewrites, unused-mode noise and frames left unterminated.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 79;
        recv_idle_pct = 26;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_regs(FmtW'($urandom_range(7)),
                   3'(($urandom_range(1) != 0) ? BppFour : BppRst),
                   pick_ticks(), pick_ticks(), pick_ticks(), $urandom_range(3) == 0);
      n_words = 0;
      while (n_words < PhaseWords) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          word_backlog.push_back(load_word(8'($urandom_range(255)),
                                           8'($urandom_range(255))));
          n_words++;
        end else if (pick < 12) begin
          word_backlog.push_back(ignored_word());
        end else begin
          len = $urandom_range(1, 5);
          repeat (len)
            word_backlog.push_back(pixel_word(pick_byte(), pick_byte(), pick_byte(),
                                              pick_byte()));
          n_words += len;
          if ($urandom_range(9) != 0) begin
            word_backlog.push_back(eof_word());
            n_words++;
          end
        end
      end
      settle();
    end

    if (fault_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lpgws_pkg.sv
hdl/lpgws_ram.sv
hdl/lpgws_front.sv
hdl/lpgws_fifo.sv
hdl/lpgws_back.sv
hdl/led_pixel_gamma_ws2812_encoder_top.sv
hdl/lpgws_checker.sv
tb/sv/tb_led_pixel_gamma_ws2812_encoder_top.sv
